FILE: src/raycast_column_texturer_macros.svh
// Assertion macros shared by the raycast column texturer RTL.
`ifndef RAYCAST_COLUMN_TEXTURER_MACROS_SVH
`define RAYCAST_COLUMN_TEXTURER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define RCT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("raycast column texturer: assertion failed");

`define RCT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("raycast column texturer: assertion failed");

`else

`define RCT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define RCT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: src/rct_pkg.sv
// Shared types, codes and constants of the raycast column texturer.
`timescale 1ns / 1ps

package rct_pkg;

  localparam int SCREEN_ROWS_DEF = 1024;
  localparam int TEXTURE_DIM_DEF = 64;

  localparam logic [23:0] HALF_MASK = 24'h7F7F7F;
  localparam logic [6:0]  TEX_SIZE_RESET = 7'd64;

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_RENDER = 1'b1;

  localparam logic [1:0] FACE_NORTH = 2'd0;
  localparam logic [1:0] FACE_SOUTH = 2'd1;
  localparam logic [1:0] FACE_EAST  = 2'd2;
  localparam logic [1:0] FACE_WEST  = 2'd3;

  localparam logic [1:0] CFG_CEILING_COLOR  = 2'd0;
  localparam logic [1:0] CFG_FLOOR_COLOR    = 2'd1;
  localparam logic [1:0] CFG_TEXTURE_WIDTH  = 2'd2;
  localparam logic [1:0] CFG_TEXTURE_HEIGHT = 2'd3;

  typedef enum logic [1:0] {
    CLS_CEILING,
    CLS_WALL,
    CLS_FLOOR
  } cls_t;

  typedef struct packed {
    logic               req_type;
    logic [1:0]         face;
    logic [11:0]        texel_index;
    logic [23:0]        texel_color;
    logic [10:0]        column;
    logic [9:0]         row;
    logic signed [15:0] wall_top;
    logic signed [15:0] wall_bottom;
    logic [15:0]        wall_span;
    logic [15:0]        hit_fraction;
  } item_t;

  typedef struct packed {
    logic        req_type;
    logic [1:0]  face;
    logic [11:0] texel_index;
    logic [23:0] texel_color;
    logic [10:0] column;
    logic [9:0]  row;
    cls_t        cls;
  } pkt_t;

endpackage

FILE: src/rct_front.sv
// Row classification, texture column and divider numerator stages.
`timescale 1ns / 1ps

module rct_front #(
  parameter int SCREEN_ROWS = rct_pkg::SCREEN_ROWS_DEF,
  parameter int TEXTURE_DIM = rct_pkg::TEXTURE_DIM_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic [6:0]                             cfg_w,
  input  logic [6:0]                             cfg_h,
  output logic [$clog2(TEXTURE_DIM+1)-1:0]       h_clamp,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  rct_pkg::item_t                         in_item,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output rct_pkg::pkt_t                          out_pkt,
  output logic [$clog2(TEXTURE_DIM)-1:0]         out_tcol,
  output logic [16+$clog2(TEXTURE_DIM+1)-1:0]    out_num,
  output logic [15:0]                            out_span
);

  localparam int DW = $clog2(TEXTURE_DIM + 1);
  localparam int QW = $clog2(TEXTURE_DIM);
  localparam int NW = 16 + DW;

  logic               rdy1, rdy2;
  logic               v1_r, v2_r;
  rct_pkg::pkt_t      pkt1_r, pkt2_r, pkt_nxt;
  logic [15:0]        off1_r, span1_r, frac1_r, span2_r;
  logic [15:0]        off_nxt, span_nxt;
  logic [DW-1:0]      w_c;
  logic [NW-1:0]      tprod, num_nxt;
  logic [QW-1:0]      tcol2_r;
  logic [NW-1:0]      num2_r;
  logic signed [16:0] top_s, bot_s, row_s, start_s, end_s, last_row_s, diff_s;

  assign w_c = (cfg_w == 7'd0) ? DW'(1) :
               (32'(cfg_w) > TEXTURE_DIM) ? DW'(TEXTURE_DIM) : DW'(cfg_w);
  assign h_clamp = (cfg_h == 7'd0) ? DW'(1) :
                   (32'(cfg_h) > TEXTURE_DIM) ? DW'(TEXTURE_DIM) : DW'(cfg_h);

  assign rdy2     = !v2_r || out_ready;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    top_s      = 17'(in_item.wall_top);
    bot_s      = 17'(in_item.wall_bottom);
    row_s      = signed'({7'b0, in_item.row});
    last_row_s = 17'(SCREEN_ROWS - 1);
    start_s    = top_s[16] ? '0 : top_s;
    end_s      = (bot_s >= last_row_s) ? last_row_s : bot_s;
    diff_s     = row_s - top_s;
    off_nxt    = diff_s[15:0];
    span_nxt   = (in_item.wall_span == 16'd0) ? 16'd1 : in_item.wall_span;

    pkt_nxt.req_type    = in_item.req_type;
    pkt_nxt.face        = in_item.face;
    pkt_nxt.texel_index = in_item.texel_index;
    pkt_nxt.texel_color = in_item.texel_color;
    pkt_nxt.column      = in_item.column;
    pkt_nxt.row         = in_item.row;
    if (row_s < start_s) begin
      pkt_nxt.cls = rct_pkg::CLS_CEILING;
    end else if (row_s < end_s) begin
      pkt_nxt.cls = rct_pkg::CLS_WALL;
    end else begin
      pkt_nxt.cls = rct_pkg::CLS_FLOOR;
    end
  end

  assign tprod   = NW'(frac1_r) * NW'(w_c);
  assign num_nxt = NW'(off1_r) * NW'(h_clamp);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      pkt1_r  <= pkt_nxt;
      off1_r  <= off_nxt;
      span1_r <= span_nxt;
      frac1_r <= in_item.hit_fraction;
    end
    if (rdy2) begin
      pkt2_r  <= pkt1_r;
      span2_r <= span1_r;
      tcol2_r <= tprod[16 +: QW];
      num2_r  <= num_nxt;
    end
  end

  assign out_valid = v2_r;
  assign out_pkt   = pkt2_r;
  assign out_tcol  = tcol2_r;
  assign out_num   = num2_r;
  assign out_span  = span2_r;

endmodule

FILE: src/rct_divider.sv
// Pipelined restoring divider that yields the clamped texture row.
`timescale 1ns / 1ps

module rct_divider #(
  parameter int TEXTURE_DIM = rct_pkg::TEXTURE_DIM_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [$clog2(TEXTURE_DIM+1)-1:0]    h,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  rct_pkg::pkt_t                       in_pkt,
  input  logic [$clog2(TEXTURE_DIM)-1:0]      in_tcol,
  input  logic [16+$clog2(TEXTURE_DIM+1)-1:0] in_num,
  input  logic [15:0]                         in_span,
  output logic                                out_valid,
  input  logic                                out_ready,
  output rct_pkg::pkt_t                       out_pkt,
  output logic [$clog2(TEXTURE_DIM)-1:0]      out_tcol,
  output logic [$clog2(TEXTURE_DIM)-1:0]      out_trow
);

  localparam int DW = $clog2(TEXTURE_DIM + 1);
  localparam int QW = $clog2(TEXTURE_DIM);
  localparam int NW = 16 + DW;
  localparam int RW = NW + 1;
  localparam int NS = QW + 2;

  logic          v_r    [NS];
  logic          rdy    [NS+1];
  rct_pkg::pkt_t pkt_r  [NS];
  logic [QW-1:0] tcol_r [NS];
  logic [QW-1:0] q_r    [NS];
  logic [QW-1:0] q_nxt  [NS];
  logic [NW-1:0] rem_r  [QW+1];
  logic [NW-1:0] rem_nxt[QW+1];
  logic          ovf_r  [QW+1];
  logic          ovf_nxt[QW+1];
  logic [15:0]   span_r [QW+1];
  logic [RW-1:0] trial;
  logic          ge;

  always_comb begin
    rdy[NS] = out_ready;
    for (int i = NS - 1; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
  end
  assign in_ready = rdy[0];

  always_comb begin
    trial      = '0;
    ge         = 1'b0;
    rem_nxt[0] = in_num;
    q_nxt[0]   = '0;
    ovf_nxt[0] = RW'(in_num) >= (RW'(in_span) << QW);
    for (int i = 1; i <= QW; i++) begin
      trial      = RW'(rem_r[i-1]) - (RW'(span_r[i-1]) << (QW - i));
      ge         = !trial[RW-1];
      rem_nxt[i] = ge ? trial[NW-1:0] : rem_r[i-1];
      q_nxt[i]   = q_r[i-1] | (QW'(ge) << (QW - i));
      ovf_nxt[i] = ovf_r[i-1];
    end
    q_nxt[NS-1] = (ovf_r[QW] || DW'(q_r[QW]) >= h) ? QW'(h - DW'(1)) : q_r[QW];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NS; i++) begin
        v_r[i] <= 1'b0;
      end
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (rdy[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      pkt_r[0]  <= in_pkt;
      tcol_r[0] <= in_tcol;
      span_r[0] <= in_span;
    end
    for (int i = 1; i < NS; i++) begin
      if (rdy[i]) begin
        pkt_r[i]  <= pkt_r[i-1];
        tcol_r[i] <= tcol_r[i-1];
      end
    end
    for (int i = 1; i <= QW; i++) begin
      if (rdy[i]) begin
        span_r[i] <= span_r[i-1];
      end
    end
    for (int i = 0; i <= QW; i++) begin
      if (rdy[i]) begin
        rem_r[i] <= rem_nxt[i];
        ovf_r[i] <= ovf_nxt[i];
      end
    end
    for (int i = 0; i < NS; i++) begin
      if (rdy[i]) begin
        q_r[i] <= q_nxt[i];
      end
    end
  end

  assign out_valid = v_r[NS-1];
  assign out_pkt   = pkt_r[NS-1];
  assign out_tcol  = tcol_r[NS-1];
  assign out_trow  = q_r[NS-1];

endmodule

FILE: src/rct_texel_ram.sv
// Single-port synchronous texel memory with registered read data.
`timescale 1ns / 1ps

module rct_texel_ram #(
  parameter int DEPTH = 4 * rct_pkg::TEXTURE_DIM_DEF * rct_pkg::TEXTURE_DIM_DEF
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [23:0]              wdata,
  output logic [23:0]              rdata
);

  logic [23:0] mem [DEPTH];
  logic [23:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: src/raycast_column_texturer.sv
// Top level of the raycast column texturer: config, texel memory and output stage.
// Throughput: one item per cycle while out_ready back-pressure does not stall the pipeline,
// set by the one texel memory access each item makes.
// The restoring divider spends one pipeline stage per texture row bit.
// Active-low synchronous reset clears valid bits and colours; texture sizes reset to 64.
// Texel memory is uncleared; load texels before reading them, as the block does not check.
`timescale 1ns / 1ps
`include "raycast_column_texturer_macros.svh"

module raycast_column_texturer #(
  parameter int SCREEN_ROWS = rct_pkg::SCREEN_ROWS_DEF,
  parameter int TEXTURE_DIM = rct_pkg::TEXTURE_DIM_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_req_type,
  input  logic [1:0]         in_face,
  input  logic [11:0]        in_texel_index,
  input  logic [23:0]        in_texel_color,
  input  logic [10:0]        in_column,
  input  logic [9:0]         in_row,
  input  logic signed [15:0] in_wall_top,
  input  logic signed [15:0] in_wall_bottom,
  input  logic [15:0]        in_wall_span,
  input  logic [15:0]        in_hit_fraction,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [10:0]        out_pixel_column,
  output logic [9:0]         out_pixel_row,
  output logic [23:0]        out_pixel_color
);

  localparam int DW = $clog2(TEXTURE_DIM + 1);
  localparam int QW = $clog2(TEXTURE_DIM);
  localparam int NW = 16 + DW;
  localparam int unsigned FACE_TEXELS = TEXTURE_DIM * TEXTURE_DIM;
  localparam int DEPTH = 4 * TEXTURE_DIM * TEXTURE_DIM;
  localparam int AW = $clog2(DEPTH);

  logic [23:0]    ceiling_r, floor_r;
  logic [6:0]     tex_w_r, tex_h_r;
  logic [DW-1:0]  h_clamp;

  rct_pkg::item_t in_item;
  logic           fr_valid, fr_ready;
  rct_pkg::pkt_t  fr_pkt;
  logic [QW-1:0]  fr_tcol;
  logic [NW-1:0]  fr_num;
  logic [15:0]    fr_span;

  logic           div_valid;
  rct_pkg::pkt_t  div_pkt;
  logic [QW-1:0]  div_tcol, div_trow;

  logic           rdy_m, rdy_o;
  logic           v_m_r;
  rct_pkg::pkt_t  pkt_m_r;
  logic           ram_en, ram_we, in_range;
  logic [AW-1:0]  ram_addr, rd_addr, wr_addr;
  logic [23:0]    texel, shaded, color_nxt;

  logic           out_valid_r;
  logic [10:0]    column_r;
  logic [9:0]     row_r;
  logic [23:0]    color_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ceiling_r <= '0;
      floor_r   <= '0;
      tex_w_r   <= rct_pkg::TEX_SIZE_RESET;
      tex_h_r   <= rct_pkg::TEX_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rct_pkg::CFG_CEILING_COLOR:  ceiling_r <= cfg_data;
        rct_pkg::CFG_FLOOR_COLOR:    floor_r   <= cfg_data;
        rct_pkg::CFG_TEXTURE_WIDTH:  tex_w_r   <= cfg_data[6:0];
        rct_pkg::CFG_TEXTURE_HEIGHT: tex_h_r   <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  assign in_item.req_type     = in_req_type;
  assign in_item.face         = in_face;
  assign in_item.texel_index  = in_texel_index;
  assign in_item.texel_color  = in_texel_color;
  assign in_item.column       = in_column;
  assign in_item.row          = in_row;
  assign in_item.wall_top     = in_wall_top;
  assign in_item.wall_bottom  = in_wall_bottom;
  assign in_item.wall_span    = in_wall_span;
  assign in_item.hit_fraction = in_hit_fraction;

  rct_front #(
    .SCREEN_ROWS(SCREEN_ROWS),
    .TEXTURE_DIM(TEXTURE_DIM)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_w    (tex_w_r),
    .cfg_h    (tex_h_r),
    .h_clamp  (h_clamp),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(fr_valid),
    .out_ready(fr_ready),
    .out_pkt  (fr_pkt),
    .out_tcol (fr_tcol),
    .out_num  (fr_num),
    .out_span (fr_span)
  );

  rct_divider #(
    .TEXTURE_DIM(TEXTURE_DIM)
  ) u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .h        (h_clamp),
    .in_valid (fr_valid),
    .in_ready (fr_ready),
    .in_pkt   (fr_pkt),
    .in_tcol  (fr_tcol),
    .in_num   (fr_num),
    .in_span  (fr_span),
    .out_valid(div_valid),
    .out_ready(rdy_m),
    .out_pkt  (div_pkt),
    .out_tcol (div_tcol),
    .out_trow (div_trow)
  );

  assign rdy_o = !out_valid_r || out_ready;
  assign rdy_m = !v_m_r || rdy_o;

  assign in_range = 32'(div_pkt.texel_index) < FACE_TEXELS;
  assign rd_addr  = AW'(div_pkt.face) * AW'(FACE_TEXELS)
                  + AW'(div_trow) * AW'(TEXTURE_DIM) + AW'(div_tcol);
  assign wr_addr  = AW'(div_pkt.face) * AW'(FACE_TEXELS) + AW'(div_pkt.texel_index);
  assign ram_addr = (div_pkt.req_type == rct_pkg::REQ_LOAD) ? wr_addr : rd_addr;
  assign ram_en   = rdy_m && div_valid;
  assign ram_we   = ram_en && (div_pkt.req_type == rct_pkg::REQ_LOAD) && in_range;

  rct_texel_ram #(
    .DEPTH(DEPTH)
  ) u_texel_ram (
    .clk  (clk),
    .en   (ram_en),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(div_pkt.texel_color),
    .rdata(texel)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_m_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy_m) begin
        v_m_r <= div_valid;
      end
      if (rdy_o) begin
        out_valid_r <= v_m_r && (pkt_m_r.req_type == rct_pkg::REQ_RENDER);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_m) begin
      pkt_m_r <= div_pkt;
    end
    if (rdy_o && v_m_r) begin
      column_r <= pkt_m_r.column;
      row_r    <= pkt_m_r.row;
      color_r  <= color_nxt;
    end
  end

  assign shaded = (pkt_m_r.face == rct_pkg::FACE_NORTH || pkt_m_r.face == rct_pkg::FACE_SOUTH)
                ? ((texel >> 1) & rct_pkg::HALF_MASK) : texel;

  always_comb begin
    unique case (pkt_m_r.cls)
      rct_pkg::CLS_CEILING: color_nxt = ceiling_r;
      rct_pkg::CLS_WALL:    color_nxt = shaded;
      rct_pkg::CLS_FLOOR:   color_nxt = floor_r;
      default:              color_nxt = floor_r;
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_column = column_r;
  assign out_pixel_row    = row_r;
  assign out_pixel_color  = color_r;

  `RCT_ASSERT_IMP(a_empty_out_accepts, clk, rst_n, !out_valid_r, in_ready)
  `RCT_ASSERT_NXT(a_load_no_result, clk, rst_n, v_m_r && rdy_o && pkt_m_r.req_type == rct_pkg::REQ_LOAD, !out_valid_r)
  `RCT_ASSERT_IMP(a_result_from_render, clk, rst_n, out_valid_r && !$past(out_valid_r), $past(v_m_r && pkt_m_r.req_type == rct_pkg::REQ_RENDER))
  `RCT_ASSERT_IMP(a_trow_clamped, clk, rst_n, div_valid, DW'(div_trow) < h_clamp)

endmodule
